// ===== src/tdf_pkg.sv =====
package tdf_pkg;

  // Number of entries in the trajectory table
  localparam int TABLE_DEPTH = 1024;

  // Request fields of the input channel
  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_position;
    logic signed [31:0] entry_velocity;
    logic signed [31:0] entry_acceleration;
    logic signed [15:0] entry_heading;
    logic signed [31:0] measured_distance;
  } tdf_in_t;

  // Fields of one result
  typedef struct packed {
    logic signed [31:0] drive_value;
    logic signed [15:0] target_heading;
    logic               path_finished;
  } tdf_out_t;

  // One trajectory table entry
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic signed [15:0] heading;
  } tdf_entry_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [23:0] gain_prop;
    logic signed [23:0] gain_deriv;
    logic signed [23:0] gain_vel_ff;
    logic signed [23:0] gain_acc_ff;
    logic [9:0]         inv_time_step;
    logic [10:0]        segments_in_use;
  } tdf_cfg_t;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_FOLLOW  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [2:0] REG_GAIN_DERIV  = 3'd1;
  localparam logic [2:0] REG_GAIN_VEL_FF = 3'd2;
  localparam logic [2:0] REG_GAIN_ACC_FF = 3'd3;
  localparam logic [2:0] REG_INV_TSTEP   = 3'd4;
  localparam logic [2:0] REG_SEG_IN_USE  = 3'd5;

  // Register reset values
  localparam logic signed [23:0] RST_GAIN_PROP   = 24'sd78643;
  localparam logic signed [23:0] RST_GAIN_DERIV  = 24'sd0;
  localparam logic signed [23:0] RST_GAIN_VEL_FF = 24'sd65536;
  localparam logic signed [23:0] RST_GAIN_ACC_FF = 24'sd0;
  localparam logic [9:0]         RST_INV_TSTEP   = 10'd50;
  localparam logic [10:0]        RST_SEG_IN_USE  = 11'd1024;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_VEL,
    MUL_ACC,
    MUL_ERR,
    MUL_DHI,
    MUL_DLO
  } tdf_mul_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic         wr_entry;
    logic         restart;
    logic         follow;
    logic         err_en;
    logic         rate_en;
    logic         mul_en;
    tdf_mul_sel_t mul_sel;
    logic         finish;
  } tdf_cmd_t;

endpackage

// ===== src/trajectory_distance_follower_core.sv =====
// Trajectory follower with PD feedback and velocity/acceleration feedforward.
// A table write or a restart is taken at once and busy never rises
// for it, so these requests can be issued back to back. A follow step raises
// busy through its error, rate, multiply, accumulate and done states;
// its result appears on out_item with out_valid high for exactly one cycle,
// once the state is back at idle, which is also the earliest cycle a new
// request can be accepted. The time is set by the single shared 24x33
// multiplier that forms the five partial products of the drive value one per
// cycle. The receiver cannot stall: sample out_item whenever out_valid is
// high. Table entries read by a follow step must have been written since
// reset. Configuration registers may be written only while busy is low.
module trajectory_distance_follower_core import tdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  tdf_in_t     in_item,
  output logic        out_valid,
  output tdf_out_t    out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tdf_cfg_t cfg;
  tdf_cmd_t cmd;

  tdf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_item.operation),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tdf_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ===== src/tdf_regs.sv =====
module tdf_regs import tdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output tdf_cfg_t    cfg
);

  tdf_cfg_t   cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop       <= RST_GAIN_PROP;
      cfg_r.gain_deriv      <= RST_GAIN_DERIV;
      cfg_r.gain_vel_ff     <= RST_GAIN_VEL_FF;
      cfg_r.gain_acc_ff     <= RST_GAIN_ACC_FF;
      cfg_r.inv_time_step   <= RST_INV_TSTEP;
      cfg_r.segments_in_use <= RST_SEG_IN_USE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_PROP:   cfg_r.gain_prop       <= pwdata[23:0];
        REG_GAIN_DERIV:  cfg_r.gain_deriv      <= pwdata[23:0];
        REG_GAIN_VEL_FF: cfg_r.gain_vel_ff     <= pwdata[23:0];
        REG_GAIN_ACC_FF: cfg_r.gain_acc_ff     <= pwdata[23:0];
        REG_INV_TSTEP:   cfg_r.inv_time_step   <= pwdata[9:0];
        REG_SEG_IN_USE:  cfg_r.segments_in_use <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back raw register bits
  always_comb begin
    unique case (reg_idx)
      REG_GAIN_PROP:   prdata = {8'd0, cfg_r.gain_prop};
      REG_GAIN_DERIV:  prdata = {8'd0, cfg_r.gain_deriv};
      REG_GAIN_VEL_FF: prdata = {8'd0, cfg_r.gain_vel_ff};
      REG_GAIN_ACC_FF: prdata = {8'd0, cfg_r.gain_acc_ff};
      REG_INV_TSTEP:   prdata = {22'd0, cfg_r.inv_time_step};
      REG_SEG_IN_USE:  prdata = {21'd0, cfg_r.segments_in_use};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/tdf_ctrl.sv =====
module tdf_ctrl import tdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  output logic       busy,
  output logic       out_valid,
  output tdf_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_RATE,
    ST_MULP,
    ST_MULDH,
    ST_MULDL,
    ST_ACCUM,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   accept;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = start && !busy;

  // Decode the current step into datapath commands
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_VEL;
    state_nxt    = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr_entry = accept && (op == OP_WRITE);
        cmd.restart  = accept && (op == OP_RESTART);
        cmd.follow   = accept && (op == OP_FOLLOW);
        if (cmd.follow) state_nxt = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL;
        state_nxt   = ST_RATE;
      end
      ST_RATE: begin
        cmd.rate_en = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC;
        state_nxt   = ST_MULP;
      end
      ST_MULP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ERR;
        state_nxt   = ST_MULDH;
      end
      ST_MULDH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DHI;
        state_nxt   = ST_MULDL;
      end
      ST_MULDL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DLO;
        state_nxt   = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

endmodule

// ===== src/tdf_dpath.sv =====
module tdf_dpath import tdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tdf_cmd_t  cmd,
  input  tdf_cfg_t  cfg,
  input  tdf_in_t   in_item,
  output tdf_out_t  out_item
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int LW = (IW + 1 > 11) ? IW + 1 : 11;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

  tdf_entry_t mem [TABLE_DEPTH];

  logic [IW-1:0]      seg_r, seg_used_r, seg_sel, last_w, wr_addr;
  logic [LW-1:0]      siu_ext, count_w;
  logic               wr_in_range, is_last_r;
  tdf_entry_t         entry_q;
  logic signed [31:0] dist_r, prev_r, err_r, err_nxt;
  logic signed [32:0] err_diff, rate_diff;
  logic signed [10:0] inv_s;
  logic signed [43:0] rate_prod;
  logic signed [42:0] rate_r;
  logic signed [23:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [56:0] prod_w, prod_r;
  logic               prod_vld_r, prod_shift_r;
  logic signed [57:0] term_w, sum_r;
  logic [26:0]        sum_hi;
  logic signed [31:0] drive_w;
  tdf_out_t           out_r;

  assign out_item = out_r;

  // Clamp the segment count and pick the entry for this step
  assign siu_ext = LW'(cfg.segments_in_use);
  always_comb begin
    if (siu_ext == '0) begin
      count_w = LW'(1);
    end else if (siu_ext > DEPTH_L) begin
      count_w = DEPTH_L;
    end else begin
      count_w = siu_ext;
    end
  end
  assign last_w  = IW'(count_w - LW'(1));
  assign seg_sel = (seg_r > last_w) ? last_w : seg_r;

  assign wr_in_range = ({22'd0, in_item.entry_index} < 32'(TABLE_DEPTH));
  assign wr_addr     = IW'(in_item.entry_index);

  // Table write and registered read; latch request operands
  always_ff @(posedge clk) begin
    if (cmd.wr_entry && wr_in_range) begin
      mem[wr_addr] <= {in_item.entry_position, in_item.entry_velocity,
                       in_item.entry_acceleration, in_item.entry_heading};
    end
    if (cmd.follow) begin
      entry_q    <= mem[seg_sel];
      dist_r     <= in_item.measured_distance;
      seg_used_r <= seg_sel;
      is_last_r  <= (seg_sel == last_w);
    end
  end

  // Position error, saturated to 32 bits
  always_comb begin
    err_diff = {entry_q.position[31], entry_q.position} - {dist_r[31], dist_r};
    if (err_diff[32] != err_diff[31]) begin
      err_nxt = err_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_nxt = err_diff[31:0];
    end
  end

  // Error change scaled by the step rate
  assign rate_diff = {err_r[31], err_r} - {prev_r[31], prev_r};
  assign inv_s     = {1'b0, cfg.inv_time_step};
  assign rate_prod = rate_diff * inv_s;

  // Shared multiplier operand selection
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_VEL: begin
        mul_a = cfg.gain_vel_ff;
        mul_b = {entry_q.velocity[31], entry_q.velocity};
      end
      MUL_ACC: begin
        mul_a = cfg.gain_acc_ff;
        mul_b = {entry_q.acceleration[31], entry_q.acceleration};
      end
      MUL_ERR: begin
        mul_a = cfg.gain_prop;
        mul_b = {err_r[31], err_r};
      end
      MUL_DHI: begin
        mul_a = cfg.gain_deriv;
        mul_b = {{6{rate_r[42]}}, rate_r[42:16]};
      end
      MUL_DLO: begin
        mul_a = cfg.gain_deriv;
        mul_b = {17'd0, rate_r[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_w = mul_a * mul_b;

  // Floor each product to Q16.16; the upper derivative half is already aligned
  assign term_w = prod_shift_r ? {{17{prod_r[56]}}, prod_r[56:16]} : {prod_r[56], prod_r};

  // Saturate the sum to 32 bits
  assign sum_hi = sum_r[57:31];
  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      drive_w = sum_r[31:0];
    end else begin
      drive_w = sum_r[57] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.err_en) err_r <= err_nxt;
    if (cmd.rate_en) rate_r <= rate_prod[42:0];
    if (cmd.mul_en) begin
      prod_r       <= prod_w;
      prod_shift_r <= (cmd.mul_sel != MUL_DHI);
    end
    if (cmd.follow) begin
      sum_r <= '0;
    end else if (prod_vld_r) begin
      sum_r <= sum_r + term_w;
    end
    if (cmd.finish) begin
      out_r.drive_value    <= drive_w;
      out_r.target_heading <= entry_q.heading;
      out_r.path_finished  <= is_last_r;
    end
  end

  // Follower state: segment pointer, previous error, product valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r      <= '0;
      prev_r     <= '0;
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
      if (cmd.restart) begin
        seg_r  <= '0;
        prev_r <= '0;
      end else if (cmd.finish) begin
        prev_r <= err_r;
        seg_r  <= (seg_used_r == last_w) ? last_w : IW'(seg_used_r + IW'(1));
      end
    end
  end

endmodule

// ===== tb/trajectory_distance_follower_core_tb.sv =====
`timescale 1ns / 100ps
module trajectory_distance_follower_core_tb;
  import tdf_pkg::*;

  // Operation code that the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Tracks the follower state and the drive values still owed by the block
  class follower_scoreboard;
    tdf_cfg_t   regs;
    tdf_entry_t entries [1024];
    bit         written [1024];
    logic [9:0] segment;
    logic signed [31:0] held_error;
    tdf_out_t   expected_drives [$];
    int         failures;

    function new();
      regs.gain_prop       = RST_GAIN_PROP;
      regs.gain_deriv      = RST_GAIN_DERIV;
      regs.gain_vel_ff     = RST_GAIN_VEL_FF;
      regs.gain_acc_ff     = RST_GAIN_ACC_FF;
      regs.inv_time_step   = RST_INV_TSTEP;
      regs.segments_in_use = RST_SEG_IN_USE;
      segment    = '0;
      held_error = '0;
      failures   = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_GAIN_PROP:   regs.gain_prop       = value[23:0];
        REG_GAIN_DERIV:  regs.gain_deriv      = value[23:0];
        REG_GAIN_VEL_FF: regs.gain_vel_ff     = value[23:0];
        REG_GAIN_ACC_FF: regs.gain_acc_ff     = value[23:0];
        REG_INV_TSTEP:   regs.inv_time_step   = value[9:0];
        REG_SEG_IN_USE:  regs.segments_in_use = value[10:0];
        default: ;
      endcase
    endfunction

    // Clamp the segment count to 1..1024 and return the last usable entry
    function logic [9:0] last_segment();
      int unsigned count;
      count = regs.segments_in_use;
      if (count == 0) count = 1;
      if (count > 1024) count = 1024;
      return 10'(count - 1);
    endfunction

    // Entry that the next follow step reads
    function logic [9:0] next_entry();
      logic [9:0] last_seg;
      last_seg = last_segment();
      return (segment > last_seg) ? last_seg : segment;
    endfunction

    function logic signed [31:0] clamp32(logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'sh7fffffff;
      if (v < -96'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Exact product, floored back to Q16.16
    function logic signed [95:0] q16_product(logic signed [95:0] gain, logic signed [95:0] x);
      logic signed [95:0] p;
      p = gain * x;
      return p >>> 16;
    endfunction

    function void predict_drive(logic signed [31:0] meas);
      logic [9:0] last_seg;
      logic [9:0] seg;
      tdf_entry_t e;
      tdf_out_t   res;
      logic signed [31:0] err;
      logic signed [95:0] err_w, prev_w, rate_w, inv_w, total;
      logic signed [95:0] pos_w, vel_w, acc_w, dist_w;
      logic signed [95:0] gp_w, gd_w, gv_w, ga_w;
      last_seg = last_segment();
      seg      = next_entry();
      e        = entries[seg];
      pos_w  = $signed(e.position);
      vel_w  = $signed(e.velocity);
      acc_w  = $signed(e.acceleration);
      dist_w = meas;
      gp_w   = $signed(regs.gain_prop);
      gd_w   = $signed(regs.gain_deriv);
      gv_w   = $signed(regs.gain_vel_ff);
      ga_w   = $signed(regs.gain_acc_ff);
      inv_w  = regs.inv_time_step;
      err    = clamp32(pos_w - dist_w);
      err_w  = err;
      prev_w = held_error;
      rate_w = (err_w - prev_w) * inv_w;
      total  = q16_product(gp_w, err_w) + q16_product(gd_w, rate_w)
             + q16_product(gv_w, vel_w) + q16_product(ga_w, acc_w);
      res.drive_value    = clamp32(total);
      res.target_heading = e.heading;
      res.path_finished  = (seg == last_seg);
      expected_drives.push_back(res);
      // Advance, holding at the last entry
      held_error = err;
      segment    = (seg >= last_seg) ? last_seg : seg + 10'd1;
    endfunction

    function void note_request(tdf_in_t req);
      case (req.operation)
        OP_WRITE: begin
          entries[req.entry_index].position     = req.entry_position;
          entries[req.entry_index].velocity     = req.entry_velocity;
          entries[req.entry_index].acceleration = req.entry_acceleration;
          entries[req.entry_index].heading      = req.entry_heading;
          written[req.entry_index]              = 1'b1;
        end
        OP_FOLLOW: predict_drive(req.measured_distance);
        OP_RESTART: begin
          segment    = '0;
          held_error = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(tdf_out_t got);
      tdf_out_t want;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result drive_value %0d target_heading %0d path_finished %0b",
                 $time, got.drive_value, got.target_heading, got.path_finished);
        failures++;
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive_value !== want.drive_value) begin
        $display("%0t: drive_value expected %0d, got %0d",
                 $time, want.drive_value, got.drive_value);
        failures++;
      end
      if (got.target_heading !== want.target_heading) begin
        $display("%0t: target_heading expected %0d, got %0d",
                 $time, want.target_heading, got.target_heading);
        failures++;
      end
      if (got.path_finished !== want.path_finished) begin
        $display("%0t: path_finished expected %0b, got %0b",
                 $time, want.path_finished, got.path_finished);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  tdf_in_t     in_item;
  logic        out_valid;
  tdf_out_t    out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  follower_scoreboard sb = new();
  bit steady_run;

  trajectory_distance_follower_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every result in the cycle it is presented
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Hold the request until the block takes it, after an optional gap
  task automatic send_request(tdf_in_t req);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 65) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(req);
  endtask

  // Drop start and wait for every owed result
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_drives.size() != 0);
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block go idle, then load all six registers
  task automatic apply_settings(logic [31:0] gp, logic [31:0] gd, logic [31:0] gv,
                                logic [31:0] ga, logic [31:0] inv, logic [31:0] count);
    hold_until_drained();
    repeat (12) @(posedge clk);
    write_register(REG_GAIN_PROP, gp);
    write_register(REG_GAIN_DERIV, gd);
    write_register(REG_GAIN_VEL_FF, gv);
    write_register(REG_GAIN_ACC_FF, ga);
    write_register(REG_INV_TSTEP, inv);
    write_register(REG_SEG_IN_USE, count);
  endtask

  function automatic tdf_in_t noise_request(logic [1:0] op);
    tdf_in_t req;
    req.operation          = op;
    req.entry_index        = 10'($urandom);
    req.entry_position     = $urandom;
    req.entry_velocity     = $urandom;
    req.entry_acceleration = $urandom;
    req.entry_heading      = 16'($urandom);
    req.measured_distance  = $urandom;
    return req;
  endfunction

  // Mostly values within +-128 meters (Q16.16), sometimes any 32-bit pattern
  function automatic logic [31:0] fixed_value();
    if ($urandom_range(0, 99) < 70) return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
    return $urandom;
  endfunction

  function automatic tdf_in_t entry_write(logic [9:0] idx, logic [31:0] pos, logic [31:0] vel,
                                          logic [31:0] acc, logic [15:0] head);
    tdf_in_t req;
    req = noise_request(OP_WRITE);
    req.entry_index        = idx;
    req.entry_position     = pos;
    req.entry_velocity     = vel;
    req.entry_acceleration = acc;
    req.entry_heading      = head;
    return req;
  endfunction

  function automatic tdf_in_t random_write(logic [9:0] idx);
    return entry_write(idx, fixed_value(), fixed_value(), fixed_value(), 16'($urandom));
  endfunction

  // Fill the entry the step will read if it was never written
  task automatic fill_next_entry();
    logic [9:0] idx;
    idx = sb.next_entry();
    if (!sb.written[idx]) send_request(random_write(idx));
  endtask

  task automatic send_follow(logic [31:0] meas);
    tdf_in_t req;
    fill_next_entry();
    req = noise_request(OP_FOLLOW);
    req.measured_distance = meas;
    send_request(req);
  endtask

  // Distance near the segment position, or anywhere
  task automatic follow_random();
    logic [31:0] meas;
    fill_next_entry();
    if ($urandom_range(0, 99) < 60)
      meas = sb.entries[sb.next_entry()].position + 32'($urandom_range(0, 1 << 19))
           - 32'(1 << 18);
    else
      meas = $urandom;
    send_follow(meas);
  endtask

  function automatic logic [31:0] pick_gain();
    int unsigned r;
    logic signed [23:0] g;
    r = $urandom_range(0, 99);
    if (r < 5) g = 24'sh7fffff;
    else if (r < 10) g = 24'sh800000;
    else if (r < 20) g = 24'($urandom);
    else g = 24'($urandom_range(0, 1 << 19)) - 24'(1 << 18);
    return {{8{g[23]}}, g};
  endfunction

  function automatic logic [9:0] pick_index();
    if ($urandom_range(0, 99) < 70) return 10'($urandom_range(0, sb.last_segment()));
    return 10'($urandom);
  endfunction

  task automatic run_random(int unsigned items);
    int unsigned r;
    int unsigned fill;
    // Well-formed opening: load the first entries and rewind
    if ($urandom_range(0, 1) == 1) begin
      fill = sb.last_segment() + 1;
      if (fill > 8) fill = 8;
      for (int unsigned i = 0; i < fill; i++) send_request(random_write(10'(i)));
      send_request(noise_request(OP_RESTART));
    end
    repeat (items) begin
      if ($urandom_range(0, 99) < 3) hold_until_drained();
      r = $urandom_range(0, 99);
      if (r < 55) follow_random();
      else if (r < 80) send_request(random_write(pick_index()));
      else if (r < 90) send_request(noise_request(OP_RESTART));
      else send_request(noise_request(OP_UNUSED));
    end
  endtask

  initial begin
    logic [31:0] inv;
    logic [31:0] count;
    int unsigned r;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    steady_run = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes under reset settings
    send_request(entry_write(10'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h8000));
    send_request(entry_write(10'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'h7fff));
    send_request(entry_write(10'd2, 32'h0, 32'h0, 32'h0, 16'h0));
    send_request(entry_write(10'd1023, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff));
    send_request(noise_request(OP_UNUSED));
    send_follow(32'h80000000);
    send_follow(32'h7fffffff);
    send_follow(32'h0);
    send_request(noise_request(OP_RESTART));
    send_follow(32'h00010000);
    send_follow(32'hffff0000);
    send_follow(32'h00000001);

    // Lower the count below the current segment; extreme gains and rate
    apply_settings(32'hff800000, 32'h007fffff, 32'h007fffff, 32'hff800000, 32'd1023, 32'd2);
    send_follow(32'h00020000);
    send_follow(32'h80000000);
    send_request(noise_request(OP_RESTART));
    send_follow(32'h7fffffff);
    send_follow(32'h0);

    // Zero time step and a zero count
    apply_settings(32'h007fffff, 32'hff800000, 32'hff800000, 32'h007fffff, 32'd0, 32'd0);
    send_follow(32'h7fffffff);
    send_follow(32'h80000000);

    // Random phases, each with its own settings
    for (int k = 0; k < 10; k++) begin
      case (k)
        0: begin inv = 32'd1000; count = 32'd2047; end
        1: begin inv = 32'd1023; count = 32'd1024; end
        2: begin inv = 32'd1;    count = 32'd1;    end
        3: begin inv = 32'd0;    count = 32'd0;    end
        4: begin inv = 32'd50;   count = 32'd2;    end
        default: begin
          inv = $urandom_range(1, 1000);
          r   = $urandom_range(0, 99);
          count = (r < 80) ? $urandom_range(1, 16) : $urandom_range(0, 2047);
        end
      endcase
      apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), inv, count);
      steady_run = (k % 3 == 1);
      run_random(113);
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("trajectory_distance_follower_core_tb: PASS");
    end else begin
      $display("trajectory_distance_follower_core_tb: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("trajectory_distance_follower_core_tb: FAIL");
    $finish;
  end

endmodule
